// ===== hdl/board_command_byte_parser_macros.svh =====
// Assertion macros for the board command byte parser.
// Each macro expects clk and rst in scope; no other dependencies.
`ifndef BOARD_COMMAND_BYTE_PARSER_MACROS_SVH
`define BOARD_COMMAND_BYTE_PARSER_MACROS_SVH

// Same-cycle implication under reset.
`define BCBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under reset.
`define BCBP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bcbp_pkg.sv =====
// Package for the board command byte parser: mode, kind and event codes,
// and the result record. No dependencies.
`timescale 1ns / 1ps
package bcbp_pkg;

  typedef enum logic [10:0] {
    MODE_NULL    = 11'b000_0000_0001,
    MODE_ANALOG  = 11'b000_0000_0010,
    MODE_PWM     = 11'b000_0000_0100,
    MODE_DIGWR   = 11'b000_0000_1000,
    MODE_DIGRD   = 11'b000_0001_0000,
    MODE_EXTEND  = 11'b000_0010_0000,
    MODE_SETID   = 11'b000_0100_0000,
    MODE_IWRITE  = 11'b000_1000_0000,
    MODE_SETREG  = 11'b001_0000_0000,
    MODE_GETREG  = 11'b010_0000_0000,
    MODE_GETREGL = 11'b100_0000_0000
  } mode_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_OUT  = 2'd1,
    KIND_IN   = 2'd2
  } kind_t;

  localparam logic [3:0] EV_NONE    = 4'd0;
  localparam logic [3:0] EV_ANALOG  = 4'd1;
  localparam logic [3:0] EV_PWMSTRT = 4'd2;
  localparam logic [3:0] EV_PWM     = 4'd3;
  localparam logic [3:0] EV_DIGOUT  = 4'd4;
  localparam logic [3:0] EV_DIGIN   = 4'd5;
  localparam logic [3:0] EV_I2CID   = 4'd6;
  localparam logic [3:0] EV_I2CWR   = 4'd7;
  localparam logic [3:0] EV_SETREG  = 4'd8;
  localparam logic [3:0] EV_I2CRD   = 4'd9;
  localparam logic [3:0] EV_GETREG  = 4'd10;
  localparam logic [3:0] EV_UNKNOWN = 4'd11;

  localparam logic [1:0] LEFT_ONE   = 2'd1;
  localparam logic [1:0] LEFT_TWO   = 2'd2;
  localparam logic [1:0] LEFT_THREE = 2'd3;

  typedef struct packed {
    logic [3:0] event_code;
    logic [5:0] port_number;
    logic [9:0] pwm_level;
    logic       digital_level;
    logic [2:0] i2c_sequence;
    logic [4:0] i2c_slot;
    logic [7:0] i2c_device_address;
    logic [7:0] i2c_register;
    logic [7:0] i2c_byte;
    logic       read_long;
  } result_t;

endpackage

// ===== hdl/board_command_byte_parser.sv =====
// Board command byte parser: pin-control command decode, one byte per request.
// Depends on bcbp_pkg and board_command_byte_parser_macros.svh.
//
// Input channel s_*: one received protocol byte per request; bit 7 set opens a
// command, bit 7 clear adds data to the pending command.
// Output channel m_*: exactly one result per input byte, in order: an event
// code and a snapshot of the decoded port, PWM level, output level and I2C
// fields as they stand after that byte.
// Path: a byte accepted into the input register is decoded from there, and
// its result is loaded into the output register when that register is free;
// m_tvalid rises as the result enters the output register.
// Throughput: one byte per cycle while the output is not stalled, set by the
// single decode stage between the input register and the output register.
// Stall: the output register holds its result while m_tready is low; the
// input register takes one more byte if it is empty, then s_tready drops until
// the output is taken.
// Reset: both stages empty, no pending command, all fields but the event zero.
`timescale 1ns / 1ps
`include "board_command_byte_parser_macros.svh"
module board_command_byte_parser
  import bcbp_pkg::*;
#(
  parameter int PWM_MAX = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [3:0] event_code, [9:4] port_number, [19:10] pwm_level,
  // [20] digital_level, [23:21] i2c_sequence, [28:24] i2c_slot,
  // [36:29] i2c_device_address, [44:37] i2c_register, [52:45] i2c_byte,
  // [53] read_long, [55:54] zero
  output logic [55:0] m_tdata
);

  localparam logic [9:0] PwmMax = 10'(PWM_MAX);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;

  mode_t      pending_mode, pending_mode_next;
  kind_t      extend_kind, extend_kind_next;
  logic [1:0] bytes_left, bytes_left_next;
  logic [5:0] port_reg, port_reg_next;
  logic [9:0] pwm_accum, pwm_accum_next;
  logic       dout_reg, dout_reg_next;
  logic [2:0] seq_reg, seq_reg_next;
  logic [4:0] slot_reg, slot_reg_next;
  logic [7:0] addr_reg, addr_reg_next;
  logic [7:0] regaddr_reg, regaddr_reg_next;
  logic [7:0] data_reg, data_reg_next;
  logic       longread_reg, longread_reg_next;
  logic [3:0] event_next;
  logic [9:0] pwm_or;
  logic [3:0] event_reg;

  result_t    res;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_comb begin
    pending_mode_next = pending_mode;
    extend_kind_next  = extend_kind;
    bytes_left_next   = bytes_left;
    port_reg_next     = port_reg;
    pwm_accum_next    = pwm_accum;
    dout_reg_next     = dout_reg;
    seq_reg_next      = seq_reg;
    slot_reg_next     = slot_reg;
    addr_reg_next     = addr_reg;
    regaddr_reg_next  = regaddr_reg;
    data_reg_next     = data_reg;
    longread_reg_next = longread_reg;
    event_next        = EV_NONE;
    pwm_or            = pwm_accum | {4'b0, in_byte[5:0]};
    if (in_byte[7]) begin
      if (in_byte[6]) begin
        case (in_byte[5:4])
          2'b00: begin
            pending_mode_next = MODE_ANALOG;
            port_reg_next     = {2'b0, in_byte[3:0]};
            event_next        = EV_ANALOG;
          end
          2'b10: begin
            pending_mode_next = MODE_PWM;
            port_reg_next     = {2'b0, in_byte[3:0]};
            pwm_accum_next    = '0;
            event_next        = EV_PWMSTRT;
          end
          2'b01: event_next = EV_NONE;
          default: begin
            if (in_byte[3:0] == 4'hF) begin
              pending_mode_next = MODE_EXTEND;
              bytes_left_next   = LEFT_THREE;
            end else begin
              case (in_byte[3:1])
                3'd0: begin
                  pending_mode_next = MODE_SETID;
                  seq_reg_next      = {2'b0, in_byte[0]};
                  bytes_left_next   = LEFT_TWO;
                end
                3'd1: begin
                  pending_mode_next = MODE_IWRITE;
                  data_reg_next     = {in_byte[0], 7'b0};
                end
                3'd2, 3'd3: begin
                  pending_mode_next = MODE_SETREG;
                  regaddr_reg_next  = {in_byte[1], 7'b0};
                  data_reg_next     = {in_byte[0], 7'b0};
                  bytes_left_next   = LEFT_TWO;
                end
                3'd4: begin
                  longread_reg_next = in_byte[0];
                  event_next        = EV_I2CRD;
                end
                3'd5: begin
                  pending_mode_next = MODE_GETREG;
                  regaddr_reg_next  = {in_byte[0], 7'b0};
                  longread_reg_next = 1'b0;
                end
                3'd6: begin
                  pending_mode_next = MODE_GETREGL;
                  regaddr_reg_next  = {in_byte[0], 7'b0};
                  longread_reg_next = 1'b1;
                end
                default: event_next = EV_NONE;
              endcase
            end
          end
        endcase
      end else begin
        port_reg_next = {2'b0, in_byte[5:2]};
        if (in_byte[1]) begin
          pending_mode_next = MODE_DIGWR;
          dout_reg_next     = in_byte[0];
          event_next        = EV_DIGOUT;
        end else begin
          pending_mode_next = MODE_DIGRD;
          event_next        = EV_DIGIN;
        end
      end
    end else begin
      case (pending_mode)
        MODE_PWM: begin
          if (in_byte[6]) begin
            port_reg_next  = port_reg | {in_byte[5:4], 4'b0};
            pwm_accum_next = {in_byte[3:0], 6'b0};
            event_next     = EV_PWMSTRT;
          end else begin
            pwm_accum_next = (pwm_or > PwmMax) ? PwmMax : pwm_or;
            event_next     = EV_PWM;
          end
        end
        MODE_SETID: begin
          if (bytes_left == LEFT_TWO) begin
            seq_reg_next    = seq_reg | {in_byte[6:5], 1'b0};
            slot_reg_next   = in_byte[4:0];
            bytes_left_next = LEFT_ONE;
          end else begin
            addr_reg_next = in_byte;
            event_next    = EV_I2CID;
          end
        end
        MODE_IWRITE: begin
          data_reg_next = data_reg | in_byte;
          event_next    = EV_I2CWR;
        end
        MODE_SETREG: begin
          if (bytes_left == LEFT_TWO) begin
            regaddr_reg_next = regaddr_reg | in_byte;
            bytes_left_next  = LEFT_ONE;
          end else begin
            data_reg_next = data_reg | in_byte;
            event_next    = EV_SETREG;
          end
        end
        MODE_GETREG, MODE_GETREGL: begin
          regaddr_reg_next = regaddr_reg | {1'b0, in_byte[6:0]};
          event_next       = EV_GETREG;
        end
        MODE_EXTEND: begin
          if (bytes_left == LEFT_THREE) begin
            bytes_left_next = LEFT_TWO;
            if (in_byte[6:5] == 2'b00) begin
              port_reg_next    = {2'b0, in_byte[3:0]};
              extend_kind_next = in_byte[4] ? KIND_OUT : KIND_IN;
            end
          end else if (extend_kind == KIND_OUT) begin
            dout_reg_next = in_byte[3];
            port_reg_next = port_reg | {in_byte[5:4], 4'b0};
            event_next    = EV_DIGOUT;
          end else if (extend_kind == KIND_IN) begin
            port_reg_next = port_reg | {in_byte[5:4], 4'b0};
            event_next    = EV_DIGIN;
          end
        end
        default: event_next = EV_UNKNOWN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid     <= 1'b0;
      pending_mode <= MODE_NULL;
      extend_kind  <= KIND_NONE;
      bytes_left   <= '0;
      port_reg     <= '0;
      pwm_accum    <= '0;
      dout_reg     <= 1'b0;
      seq_reg      <= '0;
      slot_reg     <= '0;
      addr_reg     <= '0;
      regaddr_reg  <= '0;
      data_reg     <= '0;
      longread_reg <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
      if (in_valid) begin
        pending_mode <= pending_mode_next;
        extend_kind  <= extend_kind_next;
        bytes_left   <= bytes_left_next;
        port_reg     <= port_reg_next;
        pwm_accum    <= pwm_accum_next;
        dout_reg     <= dout_reg_next;
        seq_reg      <= seq_reg_next;
        slot_reg     <= slot_reg_next;
        addr_reg     <= addr_reg_next;
        regaddr_reg  <= regaddr_reg_next;
        data_reg     <= data_reg_next;
        longread_reg <= longread_reg_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      event_reg <= event_next;
    end
  end

  always_comb begin
    res.event_code         = event_reg;
    res.port_number        = port_reg;
    res.pwm_level          = pwm_accum;
    res.digital_level      = dout_reg;
    res.i2c_sequence       = seq_reg;
    res.i2c_slot           = slot_reg;
    res.i2c_device_address = addr_reg;
    res.i2c_register       = regaddr_reg;
    res.i2c_byte           = data_reg;
    res.read_long          = longread_reg;
  end

  assign m_tdata = {2'b0, res.read_long, res.i2c_byte, res.i2c_register,
                    res.i2c_device_address, res.i2c_slot, res.i2c_sequence,
                    res.digital_level, res.pwm_level, res.port_number,
                    res.event_code};

  `BCBP_ASSERT_NXT(a_accept_fills, s_tvalid && s_tready, in_valid,
                   "accepted request not held in input register")
  `BCBP_ASSERT_IMP(a_event_range, m_tvalid, res.event_code <= EV_UNKNOWN,
                   "event code out of range")
  `BCBP_ASSERT_IMP(a_pwm_clamp, m_tvalid && res.event_code == EV_PWM,
                   res.pwm_level <= PwmMax, "pwm level above maximum")

endmodule
